// ===== hdl/fsrs_pkg.sv =====
package fsrs_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CH_W     = 2;

    localparam int DEF_NUM_CHANNELS = 3;
    localparam int DEF_COUNT_WIDTH  = 38;

    // Counter slots inside one statistics entry.
    localparam int NUM_CNT    = 6;
    localparam int CNT_NAN    = 0;
    localparam int CNT_POSINF = 1;
    localparam int CNT_NEGINF = 2;
    localparam int CNT_BELOW  = 3;
    localparam int CNT_ABOVE  = 4;
    localparam int CNT_FINITE = 5;

    localparam logic [SAMPLE_W-1:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [SAMPLE_W-1:0] EXP_MASK  = 32'h7f80_0000;
    localparam logic [SAMPLE_W-1:0] FRAC_MASK = 32'h007f_ffff;
    localparam logic [SAMPLE_W-1:0] MAG_MASK  = 32'h7fff_ffff;
    localparam logic [SAMPLE_W-1:0] ONE_BITS  = 32'h3f80_0000;

    // Result queue between the update stage and the output port.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    // Maps a binary32 pattern onto an unsigned key with the same order.
    function automatic logic [SAMPLE_W-1:0] key_of(input logic [SAMPLE_W-1:0] b);
        logic [SAMPLE_W-1:0] k;
        if (b[SAMPLE_W-1])
        begin
            k = ~b;
        end
        else
        begin
            k = b ^ SIGN_BIT;
        end
        return k;
    endfunction

endpackage

// ===== hdl/fsrs_stat_mem.sv =====
module fsrs_stat_mem #(
    parameter int NUM_CHANNELS = fsrs_pkg::DEF_NUM_CHANNELS,
    parameter int COUNT_WIDTH  = fsrs_pkg::DEF_COUNT_WIDTH,
    parameter int ADDR_W       = 1
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             rd_en,
    input  logic [ADDR_W-1:0]                                rd_addr,
    output logic [fsrs_pkg::NUM_CNT-1:0][COUNT_WIDTH-1:0]   rd_counts,
    output logic [fsrs_pkg::SAMPLE_W-1:0]                    rd_min,
    output logic [fsrs_pkg::SAMPLE_W-1:0]                    rd_max,
    input  logic                                             wr_en,
    input  logic [ADDR_W-1:0]                                wr_addr,
    input  logic [fsrs_pkg::NUM_CNT-1:0][COUNT_WIDTH-1:0]   wr_counts,
    input  logic [fsrs_pkg::SAMPLE_W-1:0]                    wr_min,
    input  logic [fsrs_pkg::SAMPLE_W-1:0]                    wr_max
);
    import fsrs_pkg::*;

    localparam int WORD_W = NUM_CNT * COUNT_WIDTH + 2 * SAMPLE_W;

    logic [WORD_W-1:0]       mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic [WORD_W-1:0]       rd_word_reg;
    logic                    rd_hit_reg;
    logic [WORD_W-1:0]       rd_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_counts, wr_min, wr_max};
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // An entry never written since reset reads as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_hit_reg ? rd_word_reg : '0;
    assign {rd_counts, rd_min, rd_max} = rd_word;

endmodule

// ===== hdl/fsrs_update.sv =====
module fsrs_update #(
    parameter int COUNT_WIDTH = fsrs_pkg::DEF_COUNT_WIDTH
) (
    input  logic [fsrs_pkg::SAMPLE_W-1:0]                    sample,
    input  logic [fsrs_pkg::NUM_CNT-1:0][COUNT_WIDTH-1:0]   old_counts,
    input  logic [fsrs_pkg::SAMPLE_W-1:0]                    old_min,
    input  logic [fsrs_pkg::SAMPLE_W-1:0]                    old_max,
    output logic [fsrs_pkg::NUM_CNT-1:0][COUNT_WIDTH-1:0]   new_counts,
    output logic [fsrs_pkg::SAMPLE_W-1:0]                    new_min,
    output logic [fsrs_pkg::SAMPLE_W-1:0]                    new_max
);
    import fsrs_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] CNT_TOP = '1;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH-1:0] r;
        if (c == CNT_TOP)
        begin
            r = c;
        end
        else
        begin
            r = c + COUNT_WIDTH'(1);
        end
        return r;
    endfunction

    logic                is_special;
    logic                frac_nz;
    logic                neg;
    logic                mag_zero;
    logic                first;
    logic [SAMPLE_W-1:0] clean;
    logic [SAMPLE_W-1:0] key;

    assign is_special = (sample & EXP_MASK) == EXP_MASK;
    assign frac_nz    = (sample & FRAC_MASK) != '0;
    assign neg        = sample[SAMPLE_W-1];
    assign mag_zero   = (sample & MAG_MASK) == '0;
    assign first      = old_counts[CNT_FINITE] == '0;
    // Negative zero is folded into positive zero before the compare.
    assign clean      = mag_zero ? '0 : sample;
    assign key        = key_of(clean);

    always_comb
    begin
        new_counts = old_counts;
        new_min    = old_min;
        new_max    = old_max;
        if (is_special)
        begin
            if (frac_nz)
            begin
                new_counts[CNT_NAN] = bump(old_counts[CNT_NAN]);
            end
            else if (neg)
            begin
                new_counts[CNT_NEGINF] = bump(old_counts[CNT_NEGINF]);
            end
            else
            begin
                new_counts[CNT_POSINF] = bump(old_counts[CNT_POSINF]);
            end
        end
        else
        begin
            if (neg && !mag_zero)
            begin
                new_counts[CNT_BELOW] = bump(old_counts[CNT_BELOW]);
            end
            if (!neg && sample > ONE_BITS)
            begin
                new_counts[CNT_ABOVE] = bump(old_counts[CNT_ABOVE]);
            end
            if (first || key < key_of(old_min))
            begin
                new_min = clean;
            end
            if (first || key > key_of(old_max))
            begin
                new_max = clean;
            end
            new_counts[CNT_FINITE] = bump(old_counts[CNT_FINITE]);
        end
    end

endmodule

// ===== hdl/fsrs_out_queue.sv =====
module fsrs_out_queue #(
    parameter int COUNT_WIDTH = fsrs_pkg::DEF_COUNT_WIDTH
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             push,
    input  logic [fsrs_pkg::CH_W-1:0]                        push_channel,
    input  logic [fsrs_pkg::NUM_CNT-1:0][COUNT_WIDTH-1:0]   push_counts,
    input  logic [fsrs_pkg::SAMPLE_W-1:0]                    push_min,
    input  logic [fsrs_pkg::SAMPLE_W-1:0]                    push_max,
    output logic                                             head_valid,
    input  logic                                             pop,
    output logic [fsrs_pkg::CH_W-1:0]                        head_channel,
    output logic [fsrs_pkg::NUM_CNT-1:0][COUNT_WIDTH-1:0]   head_counts,
    output logic [fsrs_pkg::SAMPLE_W-1:0]                    head_min,
    output logic [fsrs_pkg::SAMPLE_W-1:0]                    head_max,
    output logic [fsrs_pkg::OQ_PTR_W:0]                      level
);
    import fsrs_pkg::*;

    logic [CH_W-1:0]                       chan_q_reg   [OQ_DEPTH];
    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0]   counts_q_reg [OQ_DEPTH];
    logic [SAMPLE_W-1:0]                   min_q_reg    [OQ_DEPTH];
    logic [SAMPLE_W-1:0]                   max_q_reg    [OQ_DEPTH];
    logic [OQ_PTR_W-1:0]                   wr_ptr_reg;
    logic [OQ_PTR_W-1:0]                   rd_ptr_reg;
    logic [OQ_PTR_W:0]                     count_reg;
    logic [OQ_PTR_W:0]                     count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            chan_q_reg[wr_ptr_reg]   <= push_channel;
            counts_q_reg[wr_ptr_reg] <= push_counts;
            min_q_reg[wr_ptr_reg]    <= push_min;
            max_q_reg[wr_ptr_reg]    <= push_max;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head_valid   = count_reg != '0;
    assign head_channel = chan_q_reg[rd_ptr_reg];
    assign head_counts  = counts_q_reg[rd_ptr_reg];
    assign head_min     = min_q_reg[rd_ptr_reg];
    assign head_max     = max_q_reg[rd_ptr_reg];
    assign level        = count_reg;

endmodule

// ===== hdl/float_sample_range_stats_top.sv =====
// Per-channel statistics of a binary32 sample stream: NaN, +/-infinity, finite,
// below-zero and above-one counts (saturating) plus the finite minimum and
// maximum, with one result word per accepted sample. The block takes one word
// per clock while in_stall is low. For each accepted sample the statistics
// memory is read at the accepting edge, and the update, write-back and queue
// push complete at the next edge. A write-back register forwards a channel's
// newest entry to a sample of the same channel right behind it. Results wait
// in a four-word queue, and in_stall rises only when that queue could
// overflow because out_stall holds it back. Entries start at zero after reset
// through one valid bit per channel, so no clearing pass is needed. A channel
// number at or above NUM_CHANNELS leaves the statistics alone and returns
// zeros.
module float_sample_range_stats_top #(
    parameter int NUM_CHANNELS = fsrs_pkg::DEF_NUM_CHANNELS,
    parameter int COUNT_WIDTH  = fsrs_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fsrs_pkg::CH_W-1:0]     channel,
    input  logic [fsrs_pkg::SAMPLE_W-1:0] sample_bits,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fsrs_pkg::CH_W-1:0]     channel_out,
    output logic [COUNT_WIDTH-1:0]        nan_total,
    output logic [COUNT_WIDTH-1:0]        pos_inf_total,
    output logic [COUNT_WIDTH-1:0]        neg_inf_total,
    output logic [COUNT_WIDTH-1:0]        below_zero_total,
    output logic [COUNT_WIDTH-1:0]        above_one_total,
    output logic [COUNT_WIDTH-1:0]        finite_total,
    output logic [fsrs_pkg::SAMPLE_W-1:0] min_value,
    output logic [fsrs_pkg::SAMPLE_W-1:0] max_value
);
    import fsrs_pkg::*;

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CH_W:0] CH_LIMIT = (CH_W+1)'(NUM_CHANNELS);

    logic                                in_accept;
    logic                                in_range;

    logic                                s1_valid_reg;
    logic                                s1_range_reg;
    logic [CH_W-1:0]                     s1_ch_reg;
    logic [SAMPLE_W-1:0]                 s1_sample_reg;
    logic [ADDR_W-1:0]                   s1_addr;

    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] rd_counts;
    logic [SAMPLE_W-1:0]                 rd_min;
    logic [SAMPLE_W-1:0]                 rd_max;

    logic                                wb_valid_reg;
    logic [ADDR_W-1:0]                   wb_addr_reg;
    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] wb_counts_reg;
    logic [SAMPLE_W-1:0]                 wb_min_reg;
    logic [SAMPLE_W-1:0]                 wb_max_reg;

    logic                                fwd_hit;
    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] cur_counts;
    logic [SAMPLE_W-1:0]                 cur_min;
    logic [SAMPLE_W-1:0]                 cur_max;
    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] new_counts;
    logic [SAMPLE_W-1:0]                 new_min;
    logic [SAMPLE_W-1:0]                 new_max;
    logic                                wr_en;

    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] push_counts;
    logic [SAMPLE_W-1:0]                 push_min;
    logic [SAMPLE_W-1:0]                 push_max;
    logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] head_counts;
    logic [OQ_PTR_W:0]                   oq_level;
    logic [OQ_PTR_W+1:0]                 pending;
    logic                                out_pop;

    assign in_accept = in_valid && !in_stall;
    assign in_range  = {1'b0, channel} < CH_LIMIT;

    // Every word in flight must find a queue slot, whatever the output side does.
    assign pending  = {1'b0, oq_level} + {{(OQ_PTR_W+1){1'b0}}, s1_valid_reg};
    assign in_stall = pending >= (OQ_PTR_W+2)'(OQ_DEPTH);

    fsrs_stat_mem #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .ADDR_W       (ADDR_W)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_accept && in_range),
        .rd_addr   (channel[ADDR_W-1:0]),
        .rd_counts (rd_counts),
        .rd_min    (rd_min),
        .rd_max    (rd_max),
        .wr_en     (wr_en),
        .wr_addr   (s1_addr),
        .wr_counts (new_counts),
        .wr_min    (new_min),
        .wr_max    (new_max)
    );

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_range_reg  <= in_range;
            s1_ch_reg     <= channel;
            s1_sample_reg <= sample_bits;
        end
        if (wr_en)
        begin
            wb_addr_reg   <= s1_addr;
            wb_counts_reg <= new_counts;
            wb_min_reg    <= new_min;
            wb_max_reg    <= new_max;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            wb_valid_reg <= wr_en;
        end
    end

    assign s1_addr = s1_ch_reg[ADDR_W-1:0];
    assign wr_en   = s1_valid_reg && s1_range_reg;

    // The memory read taken at the same edge as the last write misses that write.
    assign fwd_hit    = wb_valid_reg && (wb_addr_reg == s1_addr);
    assign cur_counts = fwd_hit ? wb_counts_reg : rd_counts;
    assign cur_min    = fwd_hit ? wb_min_reg    : rd_min;
    assign cur_max    = fwd_hit ? wb_max_reg    : rd_max;

    fsrs_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .sample     (s1_sample_reg),
        .old_counts (cur_counts),
        .old_min    (cur_min),
        .old_max    (cur_max),
        .new_counts (new_counts),
        .new_min    (new_min),
        .new_max    (new_max)
    );

    assign push_counts = s1_range_reg ? new_counts : '0;
    assign push_min    = s1_range_reg ? new_min    : '0;
    assign push_max    = s1_range_reg ? new_max    : '0;

    assign out_pop = out_valid && !out_stall;

    fsrs_out_queue #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (s1_valid_reg),
        .push_channel (s1_ch_reg),
        .push_counts  (push_counts),
        .push_min     (push_min),
        .push_max     (push_max),
        .head_valid   (out_valid),
        .pop          (out_pop),
        .head_channel (channel_out),
        .head_counts  (head_counts),
        .head_min     (min_value),
        .head_max     (max_value),
        .level        (oq_level)
    );

    assign nan_total        = head_counts[CNT_NAN];
    assign pos_inf_total    = head_counts[CNT_POSINF];
    assign neg_inf_total    = head_counts[CNT_NEGINF];
    assign below_zero_total = head_counts[CNT_BELOW];
    assign above_one_total  = head_counts[CNT_ABOVE];
    assign finite_total     = head_counts[CNT_FINITE];

endmodule

// ===== dv/tb.sv =====
package stats_tb_pkg;

    import fsrs_pkg::*;

    localparam int NCH   = DEF_NUM_CHANNELS;
    localparam int CNT_W = DEF_COUNT_WIDTH;

    typedef struct packed {
        logic [CH_W-1:0]     channel_out;
        logic [CNT_W-1:0]    nan_total;
        logic [CNT_W-1:0]    pos_inf_total;
        logic [CNT_W-1:0]    neg_inf_total;
        logic [CNT_W-1:0]    below_zero_total;
        logic [CNT_W-1:0]    above_one_total;
        logic [CNT_W-1:0]    finite_total;
        logic [SAMPLE_W-1:0] min_value;
        logic [SAMPLE_W-1:0] max_value;
    } stats_word_t;

    class channel_stats_tracker;
        logic [CNT_W-1:0]    counts [NCH][NUM_CNT];
        logic [SAMPLE_W-1:0] min_bits [NCH];
        logic [SAMPLE_W-1:0] max_bits [NCH];
        stats_word_t         expected_stats [$];
        int                  errors;

        function new();
            for (int c = 0; c < NCH; c++)
            begin
                for (int s = 0; s < NUM_CNT; s++)
                begin
                    counts[c][s] = '0;
                end
                min_bits[c] = '0;
                max_bits[c] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        // Unsigned key whose order matches the order of the floating-point values.
        function logic [SAMPLE_W-1:0] order_key(logic [SAMPLE_W-1:0] b);
            if (b[SAMPLE_W-1])
            begin
                return ~b;
            end
            return b ^ SIGN_BIT;
        endfunction

        function void bump(int c, int slot);
            if (counts[c][slot] != {CNT_W{1'b1}})
            begin
                counts[c][slot] = counts[c][slot] + 1'b1;
            end
        endfunction

        function void note_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] bits);
            stats_word_t         w;
            logic [SAMPLE_W-1:0] b;
            logic [SAMPLE_W-1:0] k;
            logic                first;
            int                  c;

            w = '0;
            w.channel_out = ch;
            c = ch;
            b = bits;
            if (c >= NCH)
            begin
                expected_stats.push_back(w);
                return;
            end
            if ((b & EXP_MASK) == EXP_MASK)
            begin
                if ((b & FRAC_MASK) != 0)
                begin
                    bump(c, CNT_NAN);
                end
                else if (b[SAMPLE_W-1])
                begin
                    bump(c, CNT_NEGINF);
                end
                else
                begin
                    bump(c, CNT_POSINF);
                end
            end
            else
            begin
                first = (counts[c][CNT_FINITE] == 0);
                if (b[SAMPLE_W-1] && (b & MAG_MASK) != 0)
                begin
                    bump(c, CNT_BELOW);
                end
                if (!b[SAMPLE_W-1] && b > ONE_BITS)
                begin
                    bump(c, CNT_ABOVE);
                end
                if ((b & MAG_MASK) == 0)
                begin
                    b = '0;
                end
                k = order_key(b);
                if (first || k < order_key(min_bits[c]))
                begin
                    min_bits[c] = b;
                end
                if (first || k > order_key(max_bits[c]))
                begin
                    max_bits[c] = b;
                end
                bump(c, CNT_FINITE);
            end
            w.nan_total        = counts[c][CNT_NAN];
            w.pos_inf_total    = counts[c][CNT_POSINF];
            w.neg_inf_total    = counts[c][CNT_NEGINF];
            w.below_zero_total = counts[c][CNT_BELOW];
            w.above_one_total  = counts[c][CNT_ABOVE];
            w.finite_total     = counts[c][CNT_FINITE];
            w.min_value        = min_bits[c];
            w.max_value        = max_bits[c];
            expected_stats.push_back(w);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t mismatch on %s: expected %0h, got %0h", $time, name, exp_v,
                         got_v);
                errors++;
            end
        endfunction

        function void check_stats(stats_word_t got);
            stats_word_t exp_w;

            if (expected_stats.size() == 0)
            begin
                $display("%0t unexpected result word: expected none, got %0h", $time, got);
                errors++;
                return;
            end
            exp_w = expected_stats.pop_front();
            compare_field("channel_out", 64'(exp_w.channel_out), 64'(got.channel_out));
            compare_field("nan_total", 64'(exp_w.nan_total), 64'(got.nan_total));
            compare_field("pos_inf_total", 64'(exp_w.pos_inf_total), 64'(got.pos_inf_total));
            compare_field("neg_inf_total", 64'(exp_w.neg_inf_total), 64'(got.neg_inf_total));
            compare_field("below_zero_total", 64'(exp_w.below_zero_total),
                          64'(got.below_zero_total));
            compare_field("above_one_total", 64'(exp_w.above_one_total),
                          64'(got.above_one_total));
            compare_field("finite_total", 64'(exp_w.finite_total), 64'(got.finite_total));
            compare_field("min_value", 64'(exp_w.min_value), 64'(got.min_value));
            compare_field("max_value", 64'(exp_w.max_value), 64'(got.max_value));
        endfunction
    endclass

endpackage

module tb;

    import fsrs_pkg::*;
    import stats_tb_pkg::*;

    localparam int RANDOM_PER_PHASE = 250;
    localparam int IDLE_LIMIT       = 5000;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic [CH_W-1:0]     channel     = '0;
    logic [SAMPLE_W-1:0] sample_bits = '0;
    logic                out_stall   = 1'b0;

    logic                in_stall;
    logic                out_valid;
    logic [CH_W-1:0]     channel_out;
    logic [CNT_W-1:0]    nan_total;
    logic [CNT_W-1:0]    pos_inf_total;
    logic [CNT_W-1:0]    neg_inf_total;
    logic [CNT_W-1:0]    below_zero_total;
    logic [CNT_W-1:0]    above_one_total;
    logic [CNT_W-1:0]    finite_total;
    logic [SAMPLE_W-1:0] min_value;
    logic [SAMPLE_W-1:0] max_value;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int idle_cycles = 0;

    channel_stats_tracker stats = new();

    float_sample_range_stats_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .channel          (channel),
        .sample_bits      (sample_bits),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .channel_out      (channel_out),
        .nan_total        (nan_total),
        .pos_inf_total    (pos_inf_total),
        .neg_inf_total    (neg_inf_total),
        .below_zero_total (below_zero_total),
        .above_one_total  (above_one_total),
        .finite_total     (finite_total),
        .min_value        (min_value),
        .max_value        (max_value)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            stats.check_stats({channel_out, nan_total, pos_inf_total, neg_inf_total,
                               below_zero_total, above_one_total, finite_total,
                               min_value, max_value});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Called right after a falling edge; returns right after a falling edge.
    task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        channel     <= ch;
        sample_bits <= bits;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        stats.note_sample(ch, bits);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (stats.pending() != 0);
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] b;
        logic [SAMPLE_W-1:0] frac;
        logic                sgn;
        int                  pick;

        pick = $urandom_range(99);
        sgn  = 1'($urandom_range(1));
        frac = $urandom() & FRAC_MASK;
        if (pick < 15)
        begin
            b = $urandom();
        end
        else if (pick < 35)
        begin
            case ($urandom_range(5))
                0: b = EXP_MASK;
                1: b = SIGN_BIT | EXP_MASK;
                2: b = {sgn, 31'b0} | EXP_MASK | ((frac == 0) ? 32'h1 : frac);
                3: b = {sgn, 31'b0};
                4: b = {sgn, 31'b0} | ONE_BITS;
                default: b = {sgn, 31'b0} | frac;
            endcase
        end
        else
        begin
            // Values clustered around 1.0 so that the min/max and above-one
            // paths see close calls.
            b = {sgn, 8'($urandom_range(135, 115)), 23'(frac)};
        end
        return b;
    endfunction

    task automatic run_random(input int count);
        logic [CH_W-1:0] ch;

        for (int i = 0; i < count; i++)
        begin
            ch = ($urandom_range(99) < 6) ? CH_W'(NCH) : CH_W'($urandom_range(NCH - 1));
            send_sample(ch, random_sample());
            if ($urandom_range(99) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct  = 35;
        recv_stall_pct = 83;

        // Channel 1 sees only non-finite words first, so min and max stay zero.
        send_sample(2'd1, EXP_MASK);
        send_sample(2'd1, SIGN_BIT | EXP_MASK);
        send_sample(2'd1, 32'h7fc0_0000);
        send_sample(2'd1, 32'hffff_ffff);
        send_sample(2'd1, 32'h7f80_0001);
        // Negative zero as the first finite word of channel 2.
        send_sample(2'd2, SIGN_BIT);
        send_sample(2'd2, 32'h0000_0000);
        send_sample(2'd0, ONE_BITS);
        send_sample(2'd0, 32'h3f80_0001);
        send_sample(2'd0, 32'h7f7f_ffff);
        send_sample(2'd0, 32'hff7f_ffff);
        send_sample(2'd0, 32'h0000_0001);
        send_sample(2'd0, 32'h8000_0001);
        send_sample(2'd0, SIGN_BIT);
        send_sample(2'd0, 32'h007f_ffff);
        send_sample(2'd0, 32'h807f_ffff);
        send_sample(2'd1, SIGN_BIT | ONE_BITS);
        send_sample(2'd1, 32'h0080_0000);
        send_sample(2'd2, 32'hbf80_0000);
        send_sample(2'd2, 32'h4000_0000);
        send_sample(2'd3, 32'hffff_ffff);
        send_sample(2'd3, 32'h3f80_0001);
        send_sample(2'd2, 32'h7f7f_ffff);

        run_random(RANDOM_PER_PHASE);
        wait_drained();

        send_idle_pct  = 83;
        recv_stall_pct = 35;
        run_random(RANDOM_PER_PHASE);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(RANDOM_PER_PHASE);
        wait_drained();

        repeat (10) @(posedge clk);
        if (stats.errors == 0 && stats.pending() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
